// ----- sv/rtd_pkg.sv -----
// Shared types, widths and ROM contents for the RTD code-to-temperature core.
// Holds the resistance curve and calibration tables and their accessor functions.
// No dependencies; imported by every module of the block.
package rtd_pkg;

    localparam int CURVE_POINTS = 12;
    localparam int CALIB_POINTS = 12;

    // Resistance in hundredths of an ohm against temperature in hundredths of a degC.
    localparam int CURVE_RES [0:CURVE_POINTS-1] = '{
        8060, 8250, 10000, 10779, 11300, 11500, 11554, 12324, 13090, 13851, 15000, 15400
    };
    localparam int CURVE_TEMP [0:CURVE_POINTS-1] = '{
        -4927, -4449, 0, 2000, 3344, 3861, 4000, 6000, 8000, 10000, 13045, 14111
    };
    // Measured against standard temperature, both in hundredths of a degC.
    localparam int CALIB_MEAS [0:CALIB_POINTS-1] = '{
        -4658, -4156, 338, 2373, 3554, 4293, 4435, 6359, 7782, 8157, 8707, 8899
    };
    localparam int CALIB_STD [0:CALIB_POINTS-1] = '{
        -4927, -4449, 0, 2000, 3344, 3861, 4000, 6000, 8000, 10000, 13045, 14111
    };

    localparam int CODE_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int TEMP_W    = 17;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID_CODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID_CODE = CFG_IDX_W'(1);

    localparam logic [LIMIT_W-1:0] MIN_CODE_RST = LIMIT_W'(66);
    localparam logic [LIMIT_W-1:0] MAX_CODE_RST = LIMIT_W'(16056);

    // Resistance per code in Q16 ohm: 500/32768 ohm scaled by 65536.
    localparam int RES_PER_CODE = 1000;
    localparam int Q16_ONE      = 65536;
    localparam int PCT_SCALE    = 100;

    localparam int X_W     = 26;
    localparam int X100_W  = 34;
    localparam int DIFF_W  = 29;
    localparam int DY_W    = 14;
    localparam int N_W     = 44;
    localparam int U_W     = 42;
    localparam int D_W     = 27;
    localparam int MAG_W   = 24;
    localparam int Q_W     = 25;
    localparam int RECIP_K = 42;

    typedef enum logic {
        TBL_CURVE,
        TBL_CALIB
    } t_table;

    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_HIGH,
        SEL_SEG
    } t_sel;

    typedef struct packed {
        logic vld;
        logic ok;
    } t_tag;

    function automatic int tbl_points(t_table tbl);
        return (tbl == TBL_CURVE) ? CURVE_POINTS : CALIB_POINTS;
    endfunction

    function automatic int tbl_x(t_table tbl, int idx);
        return (tbl == TBL_CURVE) ? CURVE_RES[idx] : CALIB_MEAS[idx];
    endfunction

    function automatic int tbl_y(t_table tbl, int idx);
        return (tbl == TBL_CURVE) ? CURVE_TEMP[idx] : CALIB_STD[idx];
    endfunction

    // Divisor scale: Q16 output for the curve, Q8 output for calibration.
    function automatic int tbl_den(t_table tbl);
        return (tbl == TBL_CURVE) ? 100 : 25600;
    endfunction

    function automatic int tbl_endscale(t_table tbl);
        return (tbl == TBL_CURVE) ? 65536 : 256;
    endfunction

    // Dividend bits dropped before the reciprocal multiply; 2**shift stays below half
    // of the smallest segment divisor.
    function automatic int tbl_shift(t_table tbl);
        return (tbl == TBL_CURVE) ? 11 : 20;
    endfunction

    function automatic int tbl_m_w(t_table tbl);
        return (tbl == TBL_CURVE) ? 30 : 21;
    endfunction

endpackage

// ----- sv/rtd_interp.sv -----
// Pipelined piecewise-linear interpolation over one constant ROM of the package.
// Segment search, slope multiply, and rounded division by reciprocal with correction.
// Depends on rtd_pkg.
module rtd_interp #(
    parameter rtd_pkg::t_table TBL = rtd_pkg::TBL_CURVE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  rtd_pkg::t_tag                     i_tag,
    input  logic signed [rtd_pkg::X_W-1:0]    i_x,
    output rtd_pkg::t_tag                     o_tag,
    output logic signed [rtd_pkg::Q_W-1:0]    o_y
);
    import rtd_pkg::*;

    localparam int NPTS  = tbl_points(TBL);
    localparam int NSEG  = NPTS - 1;
    localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;
    localparam int SHIFT = tbl_shift(TBL);
    localparam int MW    = tbl_m_w(TBL);
    localparam int UH_W  = U_W - SHIFT;
    localparam int P_W   = UH_W + MW;
    localparam int QS    = RECIP_K - SHIFT;
    localparam int QD_W  = MAG_W + D_W;
    localparam int NSTG  = 11;

    localparam longint DEN   = longint'(tbl_den(TBL));
    localparam longint ES    = longint'(tbl_endscale(TBL));
    localparam longint Y0    = longint'(tbl_y(TBL, 0));
    localparam longint YN    = longint'(tbl_y(TBL, NPTS - 1));
    localparam longint HALF  = longint'(PCT_SCALE / 2);
    localparam longint LO_V  = (Y0 >= 0) ? (ES * Y0 + HALF) / PCT_SCALE
                                         : -((-ES * Y0 + HALF) / PCT_SCALE);
    localparam longint HI_V  = (YN >= 0) ? (ES * YN + HALF) / PCT_SCALE
                                         : -((-ES * YN + HALF) / PCT_SCALE);
    localparam logic signed [Q_W-1:0]    END_LO  = Q_W'(LO_V);
    localparam logic signed [Q_W-1:0]    END_HI  = Q_W'(HI_V);
    localparam logic signed [X100_W-1:0] X_SCALE = X100_W'(PCT_SCALE);

    logic signed [X100_W-1:0] thr    [0:NPTS-1];
    logic signed [DY_W-1:0]   dy_tab [0:NSEG-1];
    logic signed [N_W-1:0]    c_tab  [0:NSEG-1];
    logic [D_W-1:0]           d_tab  [0:NSEG-1];
    logic [D_W-1:0]           h_tab  [0:NSEG-1];
    logic [MW-1:0]            m_tab  [0:NSEG-1];

    for (genvar g = 0; g < NPTS; g++) begin : g_pt
        localparam longint TV = longint'(Q16_ONE) * longint'(tbl_x(TBL, g));
        assign thr[g] = X100_W'(TV);
    end

    for (genvar g = 0; g < NSEG; g++) begin : g_seg
        localparam longint DX  = longint'(tbl_x(TBL, g + 1)) - longint'(tbl_x(TBL, g));
        localparam longint DYV = longint'(tbl_y(TBL, g + 1)) - longint'(tbl_y(TBL, g));
        localparam longint DXE = (DX > 0) ? DX : 1;
        localparam longint DYE = (DX > 0) ? DYV : 0;
        localparam longint DV  = DXE * DEN;
        localparam longint CV  = longint'(Q16_ONE) * longint'(tbl_y(TBL, g)) * DXE;
        localparam longint MV  = (longint'(1) <<< RECIP_K) / DV;
        assign dy_tab[g] = DY_W'(DYE);
        assign c_tab[g]  = N_W'(CV);
        assign d_tab[g]  = D_W'(DV);
        assign h_tab[g]  = D_W'(DV / 2);
        assign m_tab[g]  = MW'(MV);
    end

    t_tag                     r_tag  [0:NSTG-1];
    t_sel                     r_mode [1:9];
    logic [SEG_W-1:0]         r_seg  [1:8];
    logic                     r_neg  [5:9];
    logic [U_W-1:0]           r_u    [5:7];
    logic [MAG_W-1:0]         r_q0   [7:8];
    logic signed [X100_W-1:0] r_x100_0;
    logic signed [X100_W-1:0] r_x100_1;
    logic [DIFF_W-1:0]        r_diff;
    logic signed [N_W-1:0]    r_prod;
    logic signed [N_W-1:0]    r_n;
    logic [P_W-1:0]           r_p;
    logic [QD_W-1:0]          r_qd;
    logic [U_W-1:0]           r_rem;
    logic [MAG_W-1:0]         r_mag;
    logic signed [Q_W-1:0]    r_y;

    logic signed [X100_W-1:0] n_x100;
    t_sel                     n_mode;
    logic [SEG_W-1:0]         n_seg;
    logic [DIFF_W-1:0]        n_diff;
    logic signed [N_W-1:0]    n_prod;
    logic signed [N_W-1:0]    n_n;
    logic signed [N_W-1:0]    h_ext;
    logic                     n_neg;
    logic [U_W-1:0]           n_u;
    logic [P_W-1:0]           n_p;
    logic [MAG_W-1:0]         n_q0;
    logic [QD_W-1:0]          n_qd;
    logic [U_W-1:0]           n_rem;
    logic [MAG_W-1:0]         n_mag;
    logic signed [Q_W-1:0]    n_y;

    assign n_x100 = X100_W'(i_x) * X_SCALE;

    always_comb begin
        n_seg = '0;
        if (r_x100_0 <= thr[0]) begin
            n_mode = SEL_LOW;
        end else if (r_x100_0 >= thr[NPTS-1]) begin
            n_mode = SEL_HIGH;
        end else begin
            n_mode = SEL_LOW;
            for (int i = NSEG - 1; i >= 0; i--) begin
                if (r_x100_0 >= thr[i] && r_x100_0 <= thr[i+1]) begin
                    n_mode = SEL_SEG;
                    n_seg  = SEG_W'(i);
                end
            end
        end
    end

    assign n_diff = DIFF_W'(r_x100_1 - thr[r_seg[1]]);
    assign n_prod = $signed({1'b0, r_diff}) * dy_tab[r_seg[2]];
    assign n_n    = c_tab[r_seg[3]] + r_prod;
    assign h_ext  = $signed(N_W'(h_tab[r_seg[4]]));
    assign n_neg  = r_n[N_W-1];
    assign n_u    = U_W'(n_neg ? (h_ext - r_n) : (h_ext + r_n));
    assign n_p    = P_W'(r_u[5][U_W-1:SHIFT]) * P_W'(m_tab[r_seg[5]]);
    assign n_q0   = MAG_W'(r_p >> QS);
    assign n_qd   = QD_W'(n_q0) * QD_W'(d_tab[r_seg[6]]);
    assign n_rem  = r_u[7] - U_W'(r_qd);
    assign n_mag  = r_q0[8] + MAG_W'(r_rem >= U_W'(d_tab[r_seg[8]]));

    always_comb begin
        case (r_mode[9])
            SEL_LOW:  n_y = END_LO;
            SEL_HIGH: n_y = END_HI;
            SEL_SEG:  n_y = r_neg[9] ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            default:  n_y = END_LO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < NSTG; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x100_0 <= n_x100;
            r_x100_1 <= r_x100_0;
            r_mode[1] <= n_mode;
            for (int k = 2; k <= 9; k++) begin
                r_mode[k] <= r_mode[k-1];
            end
            r_seg[1] <= n_seg;
            for (int k = 2; k <= 8; k++) begin
                r_seg[k] <= r_seg[k-1];
            end
            r_diff <= n_diff;
            r_prod <= n_prod;
            r_n    <= n_n;
            r_neg[5] <= n_neg;
            for (int k = 6; k <= 9; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            r_u[5] <= n_u;
            r_u[6] <= r_u[5];
            r_u[7] <= r_u[6];
            r_p    <= n_p;
            r_q0[7] <= n_q0;
            r_q0[8] <= r_q0[7];
            r_qd   <= n_qd;
            r_rem  <= n_rem;
            r_mag  <= n_mag;
            r_y    <= n_y;
        end
    end

    assign o_tag = r_tag[NSTG-1];
    assign o_y   = r_y;

endmodule

// ----- sv/rtd_code_to_temperature_core.sv -----
// RTD code-to-temperature core: window check, resistance scaling and two interpolation pipes.
// Instantiates rtd_interp for the resistance curve and the calibration table.
// Depends on rtd_pkg.
//
// One converter code enters per clock while no stalled result holds the pipe; every stage is
// registered, so the rate is one item per cycle with no bubbles.
// A stalled result freezes the whole pipe and raises o_in_stall in the same cycle. Codes
// below min_valid_code or above max_valid_code (negative codes always) come out with
// o_reading_valid low and temperature zero. Write the limit registers only while the pipe
// is empty; o_cfg_ready is always high.
module rtd_code_to_temperature_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [rtd_pkg::CODE_W-1:0]    i_adc_code,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [rtd_pkg::TEMP_W-1:0]    o_temperature,
    output logic                                 o_reading_valid,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rtd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rtd_pkg::LIMIT_W-1:0]          i_cfg_data
);
    import rtd_pkg::*;

    logic [LIMIT_W-1:0]       r_min_code;
    logic [LIMIT_W-1:0]       r_max_code;
    t_tag                     r_tag0;
    logic signed [X_W-1:0]    r_x;
    logic                     r_out_vld;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_ok;

    logic                     en;
    t_tag                     n_tag0;
    logic signed [X_W-1:0]    n_x;
    t_tag                     curve_tag;
    logic signed [Q_W-1:0]    curve_y;
    t_tag                     calib_tag;
    logic signed [Q_W-1:0]    calib_y;

    assign en          = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_code <= MIN_CODE_RST;
            r_max_code <= MAX_CODE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_VALID_CODE: r_min_code <= i_cfg_data;
                REG_MAX_VALID_CODE: r_max_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_tag0.vld = i_in_valid;
        n_tag0.ok  = !i_adc_code[CODE_W-1]
                     && (i_adc_code[LIMIT_W-1:0] >= r_min_code)
                     && (i_adc_code[LIMIT_W-1:0] <= r_max_code);
    end

    assign n_x = $signed(X_W'(i_adc_code[LIMIT_W-1:0]) * X_W'(RES_PER_CODE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
        end else if (en) begin
            r_tag0 <= n_tag0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= n_x;
        end
    end

    rtd_interp #(
        .TBL (TBL_CURVE)
    ) u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (r_tag0),
        .i_x     (r_x),
        .o_tag   (curve_tag),
        .o_y     (curve_y)
    );

    rtd_interp #(
        .TBL (TBL_CALIB)
    ) u_calib (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (curve_tag),
        .i_x     (X_W'(curve_y)),
        .o_tag   (calib_tag),
        .o_y     (calib_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= calib_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp <= calib_tag.ok ? TEMP_W'(calib_y) : '0;
            r_ok   <= calib_tag.ok;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_temperature   = r_temp;
    assign o_reading_valid = r_ok;

endmodule

// ----- sv/rtd_chk.sv -----
// Port-level checker for the RTD code-to-temperature core, bound to the top level.
// Watches output hold, input stall cause, zero result for rejected codes, result range and reset. Depends on rtd_pkg.
module rtd_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [rtd_pkg::TEMP_W-1:0]    o_temperature,
    input logic                                 o_reading_valid
);
    import rtd_pkg::*;

    localparam logic signed [TEMP_W-1:0] TEMP_LO = -TEMP_W'(12613);
    localparam logic signed [TEMP_W-1:0] TEMP_HI = TEMP_W'(36124);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_temperature) && $stable(o_reading_valid)))
        else $error("result item changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reading_valid) |-> (o_temperature == '0))
        else $error("rejected code gave nonzero temperature");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reading_valid) |->
            (o_temperature >= TEMP_LO && o_temperature <= TEMP_HI))
        else $error("temperature outside calibration range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind rtd_code_to_temperature_core rtd_chk u_chk (.*);
